// ===== rtl/core/ble_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types and constants of the bounded list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

   localparam int Capacity  = 64;
   localparam int DataWidth = 32;
   localparam int IdxW      = $clog2(Capacity);
   localparam int CntW      = $clog2(Capacity + 1);

   typedef logic [IdxW-1:0]      idx_type;
   typedef logic [CntW-1:0]      cnt_type;
   typedef logic [DataWidth-1:0] word_type;

   typedef enum logic [2:0] {
      FUNC_APPEND  = 3'd0,
      FUNC_INSERT  = 3'd1,
      FUNC_REMOVE  = 3'd2,
      FUNC_SWAP    = 3'd3,
      FUNC_REVERSE = 3'd4,
      FUNC_SORT    = 3'd5,
      FUNC_READ    = 3'd6,
      FUNC_CLEAR   = 3'd7
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_RD_A,
      ST_RD_B,
      ST_WAIT,
      ST_WR_A,
      ST_WR_B,
      ST_DONE
   } state_type;

   // datapath memory ops per step
   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_READ_A,
      DP_READ_B,
      DP_WRITE_A,
      DP_WRITE_B
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      idx_type   addr_a;
      idx_type   addr_b;
      logic      a_from_b;   // write side a gets b's data (swap/shift)
      logic      a_from_val; // write data gets the input word (append, insert)
      logic      set_count;
      cnt_type   count;
      logic      set_rsp;
      logic      rsp_ok;
      logic      rsp_rd;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      idx_type  index;
      idx_type  second_index;
      cnt_type  count;
      logic     less;     // signed a < b of the held pair
   } dp_sts_type;

endpackage

// ===== rtl/core/ble_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_datapath
// Entry memory, held command, two read registers, count and result register.
// ----------------------------------------------------------------------------
module ble_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [2:0]          func_in,
   input  ble_pkg::idx_type    index_in,
   input  ble_pkg::idx_type    second_in,
   input  logic signed [31:0]  value_in,
   input  ble_pkg::dp_cmd_type cmd,
   output ble_pkg::dp_sts_type sts,
   output logic signed [31:0]  rd_value,
   output logic                rd_ok,
   output ble_pkg::cnt_type    rd_length
);
   ble_pkg::word_type mem [ble_pkg::Capacity];

   logic [2:0]         func_ff;
   ble_pkg::idx_type   index_ff, second_ff;
   ble_pkg::word_type  val_ff, a_ff, b_ff, wdata;
   ble_pkg::cnt_type   count_ff;
   logic signed [31:0] rval_ff;
   logic               ok_ff;

   // held command
   always_ff @(posedge clock) begin
      if (load) begin
         func_ff   <= func_in;
         index_ff  <= index_in;
         second_ff <= second_in;
         val_ff    <= value_in[ble_pkg::DataWidth-1:0];
      end
   end

   // memory: one port, read data registered
   always_comb begin
      if (cmd.a_from_val)    wdata = val_ff;
      else if (cmd.a_from_b) wdata = b_ff;
      else                   wdata = a_ff;
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         ble_pkg::DP_READ_A:  a_ff <= mem[cmd.addr_a];
         ble_pkg::DP_READ_B:  b_ff <= mem[cmd.addr_b];
         ble_pkg::DP_WRITE_A: mem[cmd.addr_a] <= wdata;
         ble_pkg::DP_WRITE_B: mem[cmd.addr_b] <= wdata;
         default: ;
      endcase
   end

   // count
   always_ff @(posedge clock) begin
      if (reset)              count_ff <= '0;
      else if (cmd.set_count) count_ff <= cmd.count;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.set_rsp) begin
         ok_ff   <= cmd.rsp_ok;
         rval_ff <= cmd.rsp_rd ? 32'(signed'(a_ff)) : '0;
      end
   end

   assign sts.func         = ble_pkg::func_type'(func_ff);
   assign sts.index        = index_ff;
   assign sts.second_index = second_ff;
   assign sts.count        = count_ff;
   assign sts.less         = $signed(a_ff) < $signed(b_ff);

   assign rd_value  = rval_ff;
   assign rd_ok     = ok_ff;
   assign rd_length = count_ff;
endmodule

// ===== rtl/core/ble_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_ctrl
// Sequencer: walks pair steps (read a, read b, wait, write a, write b) per command.
// ----------------------------------------------------------------------------
module ble_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                load,
   output ble_pkg::dp_cmd_type cmd,
   input  ble_pkg::dp_sts_type sts
);
   ble_pkg::state_type state_ff, state_in;
   ble_pkg::idx_type   i_ff, i_in, j_ff, j_in;   // pair addresses
   ble_pkg::idx_type   lim_ff, lim_in;           // sort pass end
   logic               ok_ff, ok_in;
   logic               rvalid_ff, rvalid_in;
   logic               accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ble_pkg::ST_IDLE) && !rvalid_ff;
   assign rsp_valid = rvalid_ff;
   assign load      = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ble_pkg::ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      lim_ff <= lim_in;
      ok_ff  <= ok_in;
   end

   // next state and datapath commands
   always_comb begin
      logic [ble_pkg::CntW:0] c1;
      logic                   inr, inr2;
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      lim_in    = lim_ff;
      ok_in     = ok_ff;
      rvalid_in = rvalid_ff && !rsp_ready;
      cmd       = '0;
      cmd.op    = ble_pkg::DP_NOP;
      cmd.addr_a = i_ff;
      cmd.addr_b = j_ff;
      cmd.count  = sts.count;
      c1   = {1'b0, sts.count} - 1'b1;
      inr  = {1'b0, sts.index} < sts.count;
      inr2 = {1'b0, sts.second_index} < sts.count;
      case (state_ff)
         ble_pkg::ST_IDLE: begin
            if (accept) state_in = ble_pkg::ST_DISPATCH;
         end
         ble_pkg::ST_DISPATCH: begin
            state_in = ble_pkg::ST_DONE;
            ok_in    = 1'b1;
            case (sts.func)
               ble_pkg::FUNC_APPEND: begin
                  if (sts.count < ble_pkg::CntW'(ble_pkg::Capacity)) begin
                     cmd.op         = ble_pkg::DP_WRITE_A;
                     cmd.addr_a     = sts.count[ble_pkg::IdxW-1:0];
                     cmd.a_from_val = 1'b1;
                     cmd.set_count  = 1'b1;
                     cmd.count      = sts.count + 1'b1;
                  end else ok_in = 1'b0;
               end
               ble_pkg::FUNC_INSERT: begin
                  // shift up from the top: j moves down to index
                  if (inr && sts.count < ble_pkg::CntW'(ble_pkg::Capacity)) begin
                     j_in     = sts.count[ble_pkg::IdxW-1:0];
                     i_in     = ble_pkg::IdxW'(c1);
                     state_in = ble_pkg::ST_RD_A;
                  end else ok_in = 1'b0;
               end
               ble_pkg::FUNC_REMOVE: begin
                  if (inr) begin
                     i_in     = sts.index;
                     j_in     = sts.index + 1'b1;
                     state_in = ble_pkg::ST_RD_A;
                  end else ok_in = 1'b0;
               end
               ble_pkg::FUNC_SWAP: begin
                  if (inr && inr2 && sts.index != sts.second_index) begin
                     i_in     = sts.index;
                     j_in     = sts.second_index;
                     state_in = ble_pkg::ST_RD_A;
                  end else ok_in = 1'b0;
               end
               ble_pkg::FUNC_REVERSE, ble_pkg::FUNC_SORT: begin
                  i_in   = '0;
                  j_in   = sts.func == ble_pkg::FUNC_SORT ? ble_pkg::IdxW'(1)
                                                          : ble_pkg::IdxW'(c1);
                  lim_in = ble_pkg::IdxW'(c1);
                  if (sts.count > ble_pkg::CntW'(1)) state_in = ble_pkg::ST_RD_A;
               end
               ble_pkg::FUNC_READ: begin
                  if (inr) begin
                     i_in     = sts.index;
                     state_in = ble_pkg::ST_RD_A;
                  end else ok_in = 1'b0;
               end
               default: begin
                  cmd.set_count = 1'b1;
                  cmd.count     = '0;
               end
            endcase
         end
         ble_pkg::ST_RD_A: begin
            cmd.op = ble_pkg::DP_READ_A;
            if (sts.func == ble_pkg::FUNC_READ) state_in = ble_pkg::ST_WAIT;
            else if (sts.func == ble_pkg::FUNC_INSERT && j_ff == sts.index)
               state_in = ble_pkg::ST_WR_B;
            else if (sts.func == ble_pkg::FUNC_REMOVE &&
                     {1'b0, i_ff} >= c1[ble_pkg::CntW-1:0]) begin
               // last entry reached, nothing left to pull down
               cmd.op        = ble_pkg::DP_NOP;
               cmd.set_count = 1'b1;
               cmd.count     = c1[ble_pkg::CntW-1:0];
               state_in      = ble_pkg::ST_DONE;
            end else state_in = ble_pkg::ST_RD_B;
         end
         ble_pkg::ST_RD_B: begin
            cmd.op   = ble_pkg::DP_READ_B;
            state_in = ble_pkg::ST_WAIT;
         end
         ble_pkg::ST_WAIT: begin
            state_in = ble_pkg::ST_WR_A;
            if (sts.func == ble_pkg::FUNC_READ) state_in = ble_pkg::ST_DONE;
            else if (sts.func == ble_pkg::FUNC_SORT && !sts.less) begin
               // no exchange, advance the pass
               state_in = ble_pkg::ST_RD_A;
               if (j_ff == lim_ff) begin
                  if (lim_ff == ble_pkg::IdxW'(1)) state_in = ble_pkg::ST_DONE;
                  lim_in = lim_ff - 1'b1;
                  i_in   = '0;
                  j_in   = ble_pkg::IdxW'(1);
               end else begin
                  i_in = j_ff;
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ble_pkg::ST_WR_A: begin
            // mem[i] <= b
            cmd.op       = ble_pkg::DP_WRITE_A;
            cmd.a_from_b = 1'b1;
            if (sts.func == ble_pkg::FUNC_REMOVE) begin
               i_in     = j_ff;
               j_in     = j_ff + 1'b1;
               state_in = ble_pkg::ST_RD_A;
            end else state_in = ble_pkg::ST_WR_B;
         end
         ble_pkg::ST_WR_B: begin
            // mem[j] <= a (insert: value lands at index)
            cmd.op         = ble_pkg::DP_WRITE_B;
            cmd.a_from_val = sts.func == ble_pkg::FUNC_INSERT && j_ff == sts.index;
            state_in       = ble_pkg::ST_DONE;
            case (sts.func)
               ble_pkg::FUNC_INSERT: begin
                  if (j_ff == sts.index) begin
                     cmd.set_count = 1'b1;
                     cmd.count     = sts.count + 1'b1;
                  end else begin
                     j_in     = i_ff;
                     i_in     = i_ff - 1'b1;
                     state_in = ble_pkg::ST_RD_A;
                  end
               end
               ble_pkg::FUNC_REVERSE: begin
                  if (i_ff + 1'b1 < j_ff - 1'b1) begin
                     i_in     = i_ff + 1'b1;
                     j_in     = j_ff - 1'b1;
                     state_in = ble_pkg::ST_RD_A;
                  end
               end
               ble_pkg::FUNC_SORT: begin
                  state_in = ble_pkg::ST_RD_A;
                  if (j_ff == lim_ff) begin
                     if (lim_ff == ble_pkg::IdxW'(1)) state_in = ble_pkg::ST_DONE;
                     lim_in = lim_ff - 1'b1;
                     i_in   = '0;
                     j_in   = ble_pkg::IdxW'(1);
                  end else begin
                     i_in = j_ff;
                     j_in = j_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ble_pkg::ST_DONE: begin
            cmd.set_rsp = 1'b1;
            cmd.rsp_ok  = ok_ff;
            cmd.rsp_rd  = ok_ff && sts.func == ble_pkg::FUNC_READ;
            rvalid_in   = 1'b1;
            state_in    = ble_pkg::ST_IDLE;
         end
         default: state_in = ble_pkg::ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ble_pkg::ST_IDLE |-> !req_ready)
      else $error("item taken while busy");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ble_pkg::ST_DONE |=> rsp_valid)
      else $error("result lost");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      sts.count <= ble_pkg::CntW'(ble_pkg::Capacity))
      else $error("count over capacity");
`endif
endmodule

// ===== rtl/core/bounded_list_engine_core.sv =====
`timescale 1ns / 1ps
// sort makes count*(count-1)/2 compares
// one item at a time, bounded by the single-port entry memory
// synchronous active-high reset clears count and control; entries undefined
// ----------------------------------------------------------------------------
// bounded_list_engine_core
// Bounded ordered list with insert, remove, swap, reverse, sort and read.
// ----------------------------------------------------------------------------
module bounded_list_engine_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic [5:0]         req_index,
   input  logic [5:0]         req_second_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_read_value,
   output logic               rsp_ok,
   output logic [6:0]         rsp_length
);
   ble_pkg::dp_cmd_type cmd;
   ble_pkg::dp_sts_type sts;
   logic                load;

   ble_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .load, .cmd, .sts
   );

   ble_datapath u_dp (
      .clock, .reset, .load,
      .func_in   (req_func),
      .index_in  (req_index),
      .second_in (req_second_index),
      .value_in  (req_value),
      .cmd, .sts,
      .rd_value  (rsp_read_value),
      .rd_ok     (rsp_ok),
      .rd_length (rsp_length)
   );
endmodule
